// ----- sv/rxr_pkg.sv -----
// Shared types and constants for the receive reorder ACK bitmap block.
`timescale 1ns / 1ps
`default_nettype none

package rxr_pkg;

  // Fixed field widths
  localparam int SEQ_W    = 32;
  localparam int SIZE_W   = 16;
  localparam int FLOW_W   = 4;
  localparam int SACK_W   = 64;
  localparam int FLOW_CODES = 16;

  // Packet size register value after reset
  localparam logic [SIZE_W-1:0] PKT_SIZE_RESET = 16'd1000;

  // Request action codes
  localparam logic ACTION_DATA  = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV_EXP,
    ST_DIV_SEQ,
    ST_DIV_NEXT,
    ST_DRAIN,
    ST_WRITE
  } rxr_state_t;

  // Start request to the shared divider
  typedef struct packed {
    logic              start;
    logic [SEQ_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } rxr_div_req_t;

  // Result from the shared divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SEQ_W-1:0] quotient;
  } rxr_div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/rxr_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rxr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read the addressed entry every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- sv/rxr_div.sv -----
// Iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rxr_div
  import rxr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rxr_div_req_t req,
  output rxr_div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(SEQ_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] divisor;
  logic [SIZE_W-1:0] rem;
  logic [SEQ_W-1:0]  quo;

  logic [SIZE_W:0]   trial;
  logic              fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem, quo[SEQ_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  // Control: start, count bit steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(SEQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, keep remainder, shift in quotient bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= fits ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
      quo <= {quo[SEQ_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ----- sv/rx_reorder_ack_bitmap.sv -----
// Top level: per-flow selective ACK reorder tracker with a shared iterative divider.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+------------------------------------
//   in      | request   | in_valid / in_ready          | action, flow, seq, size
//   out     | response  | out_valid / out_ready        | ack_flow, cum_ack_seq, sack_bitmap,
//           |           |                              | has_gap
//   cfg     | write     | cfg_wr_en (no wait)          | cfg_wr_data (packet size)
//
// A clear request passes through read, load and write. A data request divides the
// expected packet number and its own sequence number by the packet size, and an
// in-order one also the advanced expected number before it drains buffered packets.
// Each division holds the sequencer until the divider signals done.
// After reset a sweep zeroes every entry of the flow table; in_ready is low then.
// One request is worked at a time; in_ready is high only while idle. The result
// sits in an output register, so a new request is taken while it waits, and
// the sequencer holds before its table write until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module rx_reorder_ack_bitmap
  import rxr_pkg::*;
#(
  parameter int NUM_FLOWS   = 16,
  parameter int WINDOW_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [SIZE_W-1:0] cfg_wr_data,
  // Request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              action,
  input  wire logic [FLOW_W-1:0] flow,
  input  wire logic [SEQ_W-1:0]  seq,
  input  wire logic [SIZE_W-1:0] size,
  // ACK channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [FLOW_W-1:0]      ack_flow,
  output logic [SEQ_W-1:0]       cum_ack_seq,
  output logic [SACK_W-1:0]      sack_bitmap,
  output logic                   has_gap
);

  localparam int IDX_W  = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int WIN_IW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam int ENT_W  = SEQ_W + WINDOW_BITS;

  // Configuration register
  logic [SIZE_W-1:0] packet_size;
  logic [SIZE_W-1:0] step;

  // Sequencer and working registers
  rxr_state_t             state, state_next;
  logic [IDX_W-1:0]       clr_idx;
  logic                   act_q;
  logic [FLOW_W-1:0]      flow_q;
  logic [IDX_W-1:0]       fidx_q;
  logic [SEQ_W-1:0]       seq_q;
  logic [SIZE_W-1:0]      size_q;
  logic [SEQ_W-1:0]       exp_q;
  logic [SEQ_W-1:0]       epsn_q;
  logic [WINDOW_BITS-1:0] bm_q;
  logic                   gap_q;

  // Flow table
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_addr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [ENT_W-1:0]       ram_rdata;
  logic [SEQ_W-1:0]       rd_exp;
  logic [WINDOW_BITS-1:0] rd_bm;

  // Divider
  rxr_div_req_t div_req;
  rxr_div_rsp_t div_rsp;

  // Decision terms
  logic [SEQ_W-1:0]       diff;
  logic                   in_win;
  logic [SEQ_W-1:0]       exp_plus_size;
  logic [SEQ_W-1:0]       adv;
  logic [WINDOW_BITS-1:0] bm_shifted;
  logic                   out_free;

  // Flow number to table index, wrapped by the flow count
  logic [IDX_W-1:0] flow_map [FLOW_CODES];
  for (genvar g = 0; g < FLOW_CODES; g++) begin : g_flow_map
    assign flow_map[g] = IDX_W'(g % NUM_FLOWS);
  end

  // Hold the packet size register; zero acts as one
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size <= PKT_SIZE_RESET;
    end else if (cfg_wr_en) begin
      packet_size <= cfg_wr_data;
    end
  end
  assign step = (packet_size == '0) ? SIZE_W'(1) : packet_size;

  rxr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_FLOWS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rxr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign rd_exp = ram_rdata[WINDOW_BITS +: SEQ_W];
  assign rd_bm  = ram_rdata[WINDOW_BITS-1:0];

  // Window position of the packet and the advance of the expected packet number
  always_comb begin
    diff          = div_rsp.quotient - epsn_q;
    in_win        = (div_rsp.quotient >= epsn_q) && (diff < SEQ_W'(WINDOW_BITS));
    exp_plus_size = exp_q + SEQ_W'(size_q);
    adv           = div_rsp.quotient - epsn_q;
    if ((div_rsp.quotient < epsn_q) || (adv >= SEQ_W'(WINDOW_BITS))) begin
      bm_shifted = '0;
    end else begin
      bm_shifted = bm_q >> adv[WIN_IW-1:0];
    end
  end

  assign out_free = !out_valid || out_ready;

  // Next state, table access and divider starts
  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = fidx_q;
    ram_wdata        = {exp_q, bm_q};
    div_req.start    = 1'b0;
    div_req.dividend = seq_q;
    div_req.divisor  = step;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_idx;
        ram_wdata = '0;
        if (clr_idx == IDX_W'(NUM_FLOWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (act_q == ACTION_CLEAR) begin
          state_next = ST_WRITE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_exp;
          state_next       = ST_DIV_EXP;
        end
      end
      ST_DIV_EXP: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = seq_q;
          state_next       = ST_DIV_SEQ;
        end
      end
      ST_DIV_SEQ: begin
        if (div_rsp.done) begin
          if (in_win && (diff == '0)) begin
            div_req.start    = 1'b1;
            div_req.dividend = exp_plus_size;
            state_next       = ST_DIV_NEXT;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_DIV_NEXT: begin
        if (div_rsp.done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!bm_q[0]) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  // Working registers: capture request, load entry, update window, drain
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act_q  <= action;
          flow_q <= flow;
          fidx_q <= flow_map[flow];
          seq_q  <= seq;
          size_q <= size;
        end
      end
      ST_LOAD: begin
        gap_q <= 1'b0;
        if (act_q == ACTION_CLEAR) begin
          exp_q <= '0;
          bm_q  <= '0;
        end else begin
          exp_q <= rd_exp;
          bm_q  <= rd_bm;
        end
      end
      ST_DIV_EXP: begin
        if (div_rsp.done) begin
          epsn_q <= div_rsp.quotient;
        end
      end
      ST_DIV_SEQ: begin
        if (div_rsp.done && in_win) begin
          if (diff == '0) begin
            exp_q <= exp_plus_size;
          end else begin
            bm_q  <= bm_q | (WINDOW_BITS'(1) << diff[WIN_IW-1:0]);
            gap_q <= 1'b1;
          end
        end
      end
      ST_DIV_NEXT: begin
        if (div_rsp.done) begin
          bm_q <= bm_shifted;
        end
      end
      ST_DRAIN: begin
        if (bm_q[0]) begin
          bm_q  <= bm_q >> 1;
          exp_q <= exp_q + SEQ_W'(step);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load the ACK on write, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_WRITE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WRITE) && out_free) begin
      ack_flow    <= flow_q;
      cum_ack_seq <= exp_q;
      sack_bitmap <= SACK_W'(bm_q);
      has_gap     <= gap_q || (bm_q != '0);
    end
  end

endmodule

`default_nettype wire
